// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/drml_pkg.sv =====
// Types and rectangle geometry functions for the dirty rectangle list.
`default_nettype none
package drml_pkg;

	localparam logic [14:0] DIM_MAX = 15'h7FFF;

	typedef struct packed {
		logic        [14:0] h;
		logic        [14:0] w;
		logic signed [15:0] y;
		logic signed [15:0] x;
	} rect_t;

	typedef struct packed {
		logic  active;
		rect_t r;
	} probe_t;

	// Right edge x + w, exact in 18 bits.
	function automatic logic signed [17:0] right_of(rect_t a);
		return $signed({{2{a.x[15]}}, a.x}) + $signed({3'b000, a.w});
	endfunction

	function automatic logic signed [17:0] bottom_of(rect_t a);
		return $signed({{2{a.y[15]}}, a.y}) + $signed({3'b000, a.h});
	endfunction

	// True when o fully contains i.
	function automatic logic holds(rect_t o, rect_t i);
		return (o.x <= i.x) && (o.y <= i.y) &&
			(right_of(o) >= right_of(i)) && (bottom_of(o) >= bottom_of(i));
	endfunction

	// True when the two boxes neither overlap nor touch.
	function automatic logic apart(rect_t a, rect_t b);
		return (right_of(a) < $signed({{2{b.x[15]}}, b.x})) ||
			(right_of(b) < $signed({{2{a.x[15]}}, a.x})) ||
			(bottom_of(a) < $signed({{2{b.y[15]}}, b.y})) ||
			(bottom_of(b) < $signed({{2{a.y[15]}}, a.y}));
	endfunction

	function automatic rect_t bbox(rect_t a, rect_t b);
		logic signed [17:0] ar, br, ab, bb, mr, mb;
		logic signed [18:0] dw, dh;
		rect_t res;
		ar = right_of(a);
		br = right_of(b);
		ab = bottom_of(a);
		bb = bottom_of(b);
		mr = (ar > br) ? ar : br;
		mb = (ab > bb) ? ab : bb;
		res.x = (a.x < b.x) ? a.x : b.x;
		res.y = (a.y < b.y) ? a.y : b.y;
		dw = $signed({mr[17], mr}) - $signed({{3{res.x[15]}}, res.x});
		dh = $signed({mb[17], mb}) - $signed({{3{res.y[15]}}, res.y});
		res.w = (dw > $signed({4'b0000, DIM_MAX})) ? DIM_MAX : dw[14:0];
		res.h = (dh > $signed({4'b0000, DIM_MAX})) ? DIM_MAX : dh[14:0];
		return res;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/drml_cell.sv =====
// One list entry: checks the passing probe against its rectangle and absorbs it or hands it on.
`default_nettype none
module drml_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 live,
	input  drml_pkg::probe_t    probe_in,
	output drml_pkg::probe_t    probe_out,
	output logic                probe_act,
	input  wire                 shift_en,
	input  drml_pkg::rect_t     shift_in,
	input  wire                 wr_en,
	input  drml_pkg::rect_t     wr_data,
	output drml_pkg::rect_t     entry
);
	import drml_pkg::*;

	logic   act_q;
	rect_t  probe_r_q;
	rect_t  entry_q;
	logic   hold_e, hold_n, hit;
	rect_t  upd;

	always_comb begin
		hold_e = holds(entry_q, probe_r_q);
		hold_n = holds(probe_r_q, entry_q);
		hit    = act_q && live && (hold_e || hold_n || !apart(entry_q, probe_r_q));
		upd    = hold_n ? probe_r_q : bbox(entry_q, probe_r_q);
	end

	assign probe_out = '{active: act_q && !hit, r: probe_r_q};
	assign probe_act = act_q;
	assign entry     = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else begin
			act_q <= probe_in.active;
		end
	end

	always_ff @(posedge clk) begin
		probe_r_q <= probe_in.r;
		priority if (wr_en) begin
			entry_q <= wr_data;
		end else if (shift_en) begin
			entry_q <= shift_in;
		end else if (hit && !hold_e) begin
			entry_q <= upd;
		end else begin
			entry_q <= entry_q;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/dirty_rect_merge_list.sv =====
// Top level of the dirty rectangle list: clipping, cell chain, flush output.
`default_nettype none
`include "assert_macros.svh"
// Dirty rectangle list. Words with s_tuser = 0 add a rectangle: it is clipped to
// the buffer bound (registers 0..3), dropped when empty, and then walked down a
// chain of MAX_RECTS cells, one cell a cycle; the first cell that contains it,
// is contained by it, or overlaps/touches it absorbs it, otherwise it is
// appended (or merged into the last entry when the list is full). An add keeps
// the input busy until its probe has walked through the whole chain.
// Words with s_tuser = 1 flush: each stored rectangle leaves as one output word,
// shifted out of cell 0, followed by the union box with tuser and tlast set; a
// word is held while m_tready stalls the output, and an empty list
// gives no words. Input is taken only between items. Configuration may be
// written at any idle time and takes effect on the next add.
module dirty_rect_merge_list #(
	parameter int MAX_RECTS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [63:0] s_tdata,   // rect_x[15:0], rect_y[31:16], rect_w[46:32], rect_h[61:47]
	input  wire  [0:0]  s_tuser,   // kind
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [63:0] m_tdata,   // out_x[15:0], out_y[31:16], out_w[46:32], out_h[61:47]
	output logic [0:0]  m_tuser,   // is_union
	output logic        m_tlast,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [15:0] cfg_data
);
	import drml_pkg::*;

	localparam int CW = $clog2(MAX_RECTS + 1);
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ADD   = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;
	localparam logic [1:0] REG_BX = 2'd0;
	localparam logic [1:0] REG_BY = 2'd1;
	localparam logic [1:0] REG_BW = 2'd2;
	localparam logic [1:0] REG_BH = 2'd3;

	logic [1:0]          state_q;
	logic [CW-1:0]       count_q, wcnt_q, rem_q;
	logic                first_q;
	logic signed [15:0]  bx_q, by_q;
	logic [14:0]         bw_q, bh_q;
	rect_t               union_q, out_q;
	logic                m_tvalid_q, is_union_q, last_q;

	probe_t              chain [MAX_RECTS+1];
	rect_t               entry [MAX_RECTS];
	logic [MAX_RECTS-1:0] live, wr_en, probe_act;
	rect_t               tail_data;
	logic                tail_act, full, adv, shift_en;

	// Clip the incoming rectangle to the buffer bound.
	rect_t               in_r, clip_r, bound_r;
	logic signed [15:0]  cl_l, cl_t;
	logic signed [17:0]  cl_r, cl_b;
	logic signed [18:0]  cl_w, cl_h;
	logic                in_add, in_flush;

	always_comb begin
		in_r    = s_tdata[61:0];
		bound_r = '{h: bh_q, w: bw_q, y: by_q, x: bx_q};
		cl_l    = (in_r.x > bx_q) ? in_r.x : bx_q;
		cl_t    = (in_r.y > by_q) ? in_r.y : by_q;
		cl_r    = (right_of(in_r) < right_of(bound_r)) ? right_of(in_r) : right_of(bound_r);
		cl_b    = (bottom_of(in_r) < bottom_of(bound_r)) ? bottom_of(in_r)
			: bottom_of(bound_r);
		cl_w    = $signed({cl_r[17], cl_r}) - $signed({{3{cl_l[15]}}, cl_l});
		cl_h    = $signed({cl_b[17], cl_b}) - $signed({{3{cl_t[15]}}, cl_t});
		clip_r  = '{h: cl_h[14:0], w: cl_w[14:0], y: cl_t, x: cl_l};
		in_add  = s_tvalid && s_tready && !s_tuser[0];
		in_flush = s_tvalid && s_tready && s_tuser[0];
	end

	assign s_tready = (state_q == ST_IDLE);

	// Inject the probe into cell 0; drop empty rectangles by leaving it inactive.
	assign chain[0] = '{active: in_add && (cl_w > 19'sd0) && (cl_h > 19'sd0), r: clip_r};

	// The probe leaving the last cell matched nothing: append or merge into the tail.
	assign tail_act  = chain[MAX_RECTS].active;
	assign full      = (count_q == CW'(MAX_RECTS));
	assign tail_data = full ? bbox(entry[MAX_RECTS-1], chain[MAX_RECTS].r)
		: chain[MAX_RECTS].r;
	assign adv       = !m_tvalid_q || m_tready;
	assign shift_en  = (state_q == ST_FLUSH) && adv && (rem_q != '0);

	for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
		assign live[i]  = (CW'(i) < count_q);
		assign wr_en[i] = tail_act && (full ? (i == MAX_RECTS - 1) : (CW'(i) == count_q));
		drml_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.live      (live[i]),
			.probe_in  (chain[i]),
			.probe_out (chain[i+1]),
			.probe_act (probe_act[i]),
			.shift_en  (shift_en),
			.shift_in  ((i == MAX_RECTS - 1) ? entry[i] : entry[(i + 1) % MAX_RECTS]),
			.wr_en     (wr_en[i]),
			.wr_data   (tail_data),
			.entry     (entry[i])
		);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bx_q <= 16'sd0;
			by_q <= 16'sd0;
			bw_q <= 15'd320;
			bh_q <= 15'd240;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BX: bx_q <= cfg_data;
				REG_BY: by_q <= cfg_data;
				REG_BW: bw_q <= cfg_data[14:0];
				REG_BH: bh_q <= cfg_data[14:0];
			endcase
		end
	end

	// Sequencer: add walk, flush drain, output word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			wcnt_q     <= '0;
			rem_q      <= '0;
			first_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// Load a new word whenever the flush advances, else drop a taken one.
			if (state_q == ST_FLUSH && adv) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (tail_act && !full) begin
				count_q <= count_q + CW'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					wcnt_q <= '0;
					if (in_add) begin
						state_q <= ST_ADD;
					end else if (in_flush && count_q != '0) begin
						state_q <= ST_FLUSH;
						rem_q   <= count_q;
						first_q <= 1'b1;
					end
				end
				ST_ADD: begin
					wcnt_q <= wcnt_q + CW'(1);
					if (wcnt_q == CW'(MAX_RECTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (adv) begin
						if (rem_q != '0) begin
							rem_q   <= rem_q - CW'(1);
							first_q <= 1'b0;
						end else begin
							count_q <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output payload and running union; hold while the word is stalled.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			out_q      <= entry[0];
			is_union_q <= 1'b0;
			last_q     <= 1'b0;
			union_q    <= first_q ? entry[0] : bbox(union_q, entry[0]);
		end else if (state_q == ST_FLUSH && adv) begin
			out_q      <= union_q;
			is_union_q <= 1'b1;
			last_q     <= 1'b1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, out_q};
	assign m_tuser  = is_union_q;
	assign m_tlast  = last_q;

	`ASSERT_CLK(a_count_bound, count_q <= CW'(MAX_RECTS), "rect count above list size")
	`ASSERT_ALWAYS(a_one_probe, $onehot0(probe_act), "more than one probe in the chain")
	`ASSERT_CLK(a_flush_clears, (state_q == ST_FLUSH) ##1 (state_q == ST_IDLE) |-> count_q == '0,
		"list not cleared after flush")
	`ASSERT_CLK(a_last_union, m_tvalid && m_tlast |-> m_tuser[0], "last word is not the union")
endmodule
`default_nettype wire
